[hw/rtl/fdrs_pkg.sv]
// fdrs_pkg: shared types and constants of the fault domain restart supervisor
// used by fdrs_ctrl, fdrs_dp and the top level; no dependencies
`timescale 1ns / 1ps
package fdrs_pkg;

  localparam int NumDomains = 16;
  localparam int DomIdxW    = 4;
  localparam int DomCntW    = 5;
  localparam int MaxEdges   = 64;
  localparam int EdgeIdxW   = 6;
  localparam int EdgeCntW   = 7;
  localparam int HistDepth  = 4;
  localparam int HistIdxW   = 2;
  localparam int HistCntW   = 3;

  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_ADD_DEP  = 3'd1;
  localparam logic [2:0] OP_MARK     = 3'd2;
  localparam logic [2:0] OP_RESTART  = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;
  localparam logic [2:0] OP_QUERY    = 3'd5;

  localparam logic [1:0] MS_RUN   = 2'd0;
  localparam logic [1:0] MS_CRASH = 2'd1;
  localparam logic [1:0] MS_STOP  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_TD_FAIL   = 3'd2,
    ST_INIT_FAIL = 3'd3,
    ST_THROTTLED = 3'd4,
    ST_REFUSED   = 3'd5,
    ST_NOTHING   = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  domain_id;
    logic [7:0]  dependent_id;
    logic [63:0] cur_time;
    logic [15:0] teardown_ok_mask;
    logic [15:0] init_ok_mask;
  } fdrs_in_t;

  typedef struct packed {
    logic [3:0]  result_domain;
    logic [2:0]  status;
    logic [1:0]  module_state;
    logic        alive;
    logic        pending;
    logic [31:0] restart_total;
    logic [31:0] domain_throttles;
    logic [63:0] global_throttles;
    logic [4:0]  domains_in_use;
    logic [6:0]  edges_in_use;
    logic        last;
  } fdrs_out_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_TICK_INIT,
    ACT_REG,
    ACT_ADD_EDGE,
    ACT_MARK,
    ACT_CRASH,
    ACT_HIST,
    ACT_THROTTLE,
    ACT_RESTART,
    ACT_EDGE
  } act_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_TSCAN,
    S_HIST,
    S_HCMP,
    S_THROT,
    S_RESTART,
    S_EDGE,
    S_EMIT
  } state_e;

  typedef struct packed {
    act_e    act;
    logic    emit;
    logic    last;
    logic    has;
    status_e status;
    logic    clr_pend;
    logic    idx_inc;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       found;
    logic       dep_found;
    logic       same;
    logic       reg_full;
    logic       edge_full;
    logic       idx_end;
    logic       pend_cur;
    logic       cnt_full;
    logic       td_ok;
    logic       init_ok;
    logic       edge_done;
    logic       hist_done;
    logic       too_fast;
    logic       more_pend;
    logic       out_free;
  } sts_t;

endpackage

[hw/rtl/fdrs_ram.sv]
// fdrs_ram: generic one-write one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module fdrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fdrs_ctrl.sv]
// fdrs_ctrl: sequencing state machine of the restart supervisor
// depends on fdrs_pkg; drives the datapath through cmd_t, reads sts_t
`timescale 1ns / 1ps
module fdrs_ctrl import fdrs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e  state_q, state_d;
  status_e res_status_q, res_status_d;
  logic    res_has_q, res_has_d;
  logic    tick_q, tick_d;
  logic    last_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= ST_OK;
      res_has_q    <= 1'b0;
      tick_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_has_q    <= res_has_d;
      tick_q       <= tick_d;
    end
  end

  assign last_w = !(tick_q && res_has_q && sts_i.more_pend);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        if (sts_i.opcode == OP_TICK) state_d = S_TSCAN;
        else if (sts_i.opcode == OP_RESTART && sts_i.found) state_d = S_RESTART;
        else state_d = S_EMIT;
      end
      S_TSCAN: begin
        if (sts_i.idx_end) state_d = S_EMIT;
        else if (sts_i.pend_cur) state_d = sts_i.cnt_full ? S_HIST : S_RESTART;
      end
      S_HIST: begin
        if (sts_i.hist_done) state_d = S_HCMP;
      end
      S_HCMP: state_d = sts_i.too_fast ? S_THROT : S_RESTART;
      S_THROT: state_d = S_EMIT;
      S_RESTART: begin
        state_d = (sts_i.td_ok && sts_i.init_ok) ? S_EDGE : S_EMIT;
      end
      S_EDGE: begin
        if (sts_i.edge_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) state_d = last_w ? S_IDLE : S_TSCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.act      = ACT_NONE;
    cmd_o.status   = ST_OK;
    in_ready_o     = 1'b0;
    res_status_d   = res_status_q;
    res_has_d      = res_has_q;
    tick_d         = tick_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.act = ACT_LATCH;
      end
      S_DEC: begin
        tick_d = 1'b0;
        unique case (sts_i.opcode)
          OP_REGISTER: begin
            if (sts_i.reg_full) begin
              res_has_d = 1'b0; res_status_d = ST_REFUSED;
            end else begin
              cmd_o.act = ACT_REG;
              res_has_d = 1'b1; res_status_d = ST_OK;
            end
          end
          OP_ADD_DEP: begin
            if (!sts_i.found || !sts_i.dep_found) begin
              res_has_d = sts_i.found; res_status_d = ST_NOT_FOUND;
            end else if (sts_i.same || sts_i.edge_full) begin
              res_has_d = 1'b1; res_status_d = ST_REFUSED;
            end else begin
              cmd_o.act = ACT_ADD_EDGE;
              res_has_d = 1'b1; res_status_d = ST_OK;
            end
          end
          OP_MARK: begin
            if (sts_i.found) cmd_o.act = ACT_MARK;
            res_has_d    = sts_i.found;
            res_status_d = sts_i.found ? ST_OK : ST_NOT_FOUND;
          end
          OP_RESTART: begin
            res_has_d    = 1'b0;
            res_status_d = ST_NOT_FOUND;
          end
          OP_TICK: begin
            cmd_o.act = ACT_TICK_INIT;
            tick_d    = 1'b1;
          end
          OP_QUERY: begin
            res_has_d    = sts_i.found;
            res_status_d = sts_i.found ? ST_OK : ST_NOT_FOUND;
          end
          default: begin
            res_has_d = 1'b0; res_status_d = ST_NOTHING;
          end
        endcase
      end
      S_TSCAN: begin
        if (sts_i.idx_end) begin
          res_has_d = 1'b0; res_status_d = ST_NOTHING;
        end else if (sts_i.pend_cur) begin
          cmd_o.act = ACT_CRASH;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_HIST: cmd_o.act = ACT_HIST;
      S_HCMP: ;
      S_THROT: begin
        cmd_o.act = ACT_THROTTLE;
        res_has_d = 1'b1; res_status_d = ST_THROTTLED;
      end
      S_RESTART: begin
        cmd_o.act      = ACT_RESTART;
        cmd_o.clr_pend = tick_q;
        res_has_d      = 1'b1;
        priority if (!sts_i.td_ok) res_status_d = ST_TD_FAIL;
        else if (!sts_i.init_ok) res_status_d = ST_INIT_FAIL;
        else res_status_d = ST_OK;
      end
      S_EDGE: cmd_o.act = ACT_EDGE;
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.has     = res_has_q;
          cmd_o.status  = res_status_q;
          cmd_o.last    = last_w;
          cmd_o.idx_inc = tick_q;
        end
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE && cmd_o.emit == 1'b0))
    else $error("ready outside idle");
  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_DEC)
    else $error("accepted transfer not decoded");
  a_emit_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> state_q == S_IDLE)
    else $error("final result did not end the item");

endmodule

[hw/rtl/fdrs_dp.sv]
// fdrs_dp: domain table, counters, edge and history rams, output register
// depends on fdrs_pkg and fdrs_ram; commanded by fdrs_ctrl
`timescale 1ns / 1ps
module fdrs_dp import fdrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fdrs_in_t    in_data_i,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fdrs_out_t   out_data_o
);

  fdrs_in_t          item_q, item_d;
  logic [63:0]       window_q;
  logic [DomCntW-1:0]  idx_q, idx_d, dom_total_q, dom_total_d;
  logic [EdgeCntW-1:0] edge_total_q, edge_total_d, eidx_q, eidx_d;
  logic              erv_q, erv_d;
  logic [HistCntW-1:0] hk_q, hk_d;
  logic              hv_q, hv_d, minv_q, minv_d;
  logic [63:0]       min_q, min_d, tsum_q, tsum_d;
  logic              alive_q [NumDomains], alive_d [NumDomains];
  logic              pend_q [NumDomains], pend_d [NumDomains];
  logic [1:0]        mst_q [NumDomains], mst_d [NumDomains];
  logic [31:0]       rcnt_q [NumDomains], rcnt_d [NumDomains];
  logic [31:0]       tcnt_q [NumDomains], tcnt_d [NumDomains];
  logic [HistIdxW-1:0] hnext_q [NumDomains], hnext_d [NumDomains];
  logic              out_valid_q, out_valid_d;
  fdrs_out_t         out_q, out_d;

  logic [DomIdxW-1:0] cur;
  logic               e_issue, h_issue, hist_we, more_pend;
  logic [2*DomIdxW-1:0] edge_rdata;
  logic [63:0]        hist_rdata;
  logic [DomIdxW-1:0] e_par, e_dep;

  assign cur     = idx_q[DomIdxW-1:0];
  assign e_issue = (cmd_i.act == ACT_EDGE) && (eidx_q < edge_total_q);
  assign h_issue = (cmd_i.act == ACT_HIST) && (hk_q < HistCntW'(HistDepth));
  assign hist_we = (cmd_i.act == ACT_RESTART) && item_q.teardown_ok_mask[cur]
                   && item_q.init_ok_mask[cur];
  assign e_par   = edge_rdata[2*DomIdxW-1:DomIdxW];
  assign e_dep   = edge_rdata[DomIdxW-1:0];

  fdrs_ram #(.Width(2*DomIdxW), .Depth(MaxEdges)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.act == ACT_ADD_EDGE),
    .waddr_i (edge_total_q[EdgeIdxW-1:0]),
    .wdata_i ({item_q.domain_id[DomIdxW-1:0], item_q.dependent_id[DomIdxW-1:0]}),
    .re_i    (e_issue),
    .raddr_i (eidx_q[EdgeIdxW-1:0]),
    .rdata_o (edge_rdata)
  );

  fdrs_ram #(.Width(64), .Depth(NumDomains * HistDepth)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i ({cur, hnext_q[cur]}),
    .wdata_i (item_q.cur_time),
    .re_i    (h_issue),
    .raddr_i ({cur, hk_q[HistIdxW-1:0]}),
    .rdata_o (hist_rdata)
  );

  always_comb begin
    more_pend = 1'b0;
    for (int i = 0; i < NumDomains; i++) begin
      if (pend_q[i] && (DomCntW'(i) > idx_q) && (DomCntW'(i) < dom_total_q)) begin
        more_pend = 1'b1;
      end
    end
  end

  always_comb begin
    sts_o.opcode    = item_q.opcode;
    sts_o.found     = item_q.domain_id < 8'(dom_total_q);
    sts_o.dep_found = item_q.dependent_id < 8'(dom_total_q);
    sts_o.same      = item_q.domain_id == item_q.dependent_id;
    sts_o.reg_full  = dom_total_q >= DomCntW'(NumDomains);
    sts_o.edge_full = edge_total_q >= EdgeCntW'(MaxEdges);
    sts_o.idx_end   = idx_q >= dom_total_q;
    sts_o.pend_cur  = pend_q[cur];
    sts_o.cnt_full  = rcnt_q[cur] >= 32'(HistDepth);
    sts_o.td_ok     = item_q.teardown_ok_mask[cur];
    sts_o.init_ok   = item_q.init_ok_mask[cur];
    sts_o.edge_done = !(eidx_q < edge_total_q) && !erv_q;
    sts_o.hist_done = !(hk_q < HistCntW'(HistDepth)) && !hv_q;
    sts_o.too_fast  = (item_q.cur_time - min_q) < window_q;
    sts_o.more_pend = more_pend;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    item_d       = item_q;
    idx_d        = idx_q;
    dom_total_d  = dom_total_q;
    edge_total_d = edge_total_q;
    eidx_d       = eidx_q;
    erv_d        = erv_q;
    hk_d         = hk_q;
    hv_d         = hv_q;
    minv_d       = minv_q;
    min_d        = min_q;
    tsum_d       = tsum_q;
    alive_d      = alive_q;
    pend_d       = pend_q;
    mst_d        = mst_q;
    rcnt_d       = rcnt_q;
    tcnt_d       = tcnt_q;
    hnext_d      = hnext_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    unique case (cmd_i.act)
      ACT_NONE: ;
      ACT_LATCH: begin
        item_d = in_data_i;
        idx_d  = {1'b0, in_data_i.domain_id[DomIdxW-1:0]};
      end
      ACT_TICK_INIT: idx_d = '0;
      ACT_REG: begin
        alive_d[dom_total_q[DomIdxW-1:0]] = 1'b1;
        pend_d[dom_total_q[DomIdxW-1:0]]  = 1'b0;
        mst_d[dom_total_q[DomIdxW-1:0]]   = MS_RUN;
        rcnt_d[dom_total_q[DomIdxW-1:0]]  = '0;
        idx_d       = dom_total_q;
        dom_total_d = dom_total_q + 1'b1;
      end
      ACT_ADD_EDGE: edge_total_d = edge_total_q + 1'b1;
      ACT_MARK: pend_d[cur] = 1'b1;
      ACT_CRASH: begin
        mst_d[cur] = MS_CRASH;
        hk_d       = '0;
        hv_d       = 1'b0;
        minv_d     = 1'b0;
      end
      ACT_HIST: begin
        if (h_issue) hk_d = hk_q + 1'b1;
        hv_d = h_issue;
        if (hv_q) begin
          if (!minv_q || hist_rdata < min_q) min_d = hist_rdata;
          minv_d = 1'b1;
        end
      end
      ACT_THROTTLE: begin
        pend_d[cur]  = 1'b0;
        alive_d[cur] = 1'b0;
        mst_d[cur]   = MS_STOP;
        tcnt_d[cur]  = tcnt_q[cur] + 1'b1;
        tsum_d       = tsum_q + 1'b1;
      end
      ACT_RESTART: begin
        alive_d[cur] = 1'b0;
        if (cmd_i.clr_pend) pend_d[cur] = 1'b0;
        if (hist_we) begin
          alive_d[cur] = 1'b1;
          pend_d[cur]  = 1'b0;
          mst_d[cur]   = MS_RUN;
          rcnt_d[cur]  = rcnt_q[cur] + 1'b1;
          hnext_d[cur] = hnext_q[cur] + 1'b1;
          eidx_d       = '0;
          erv_d        = 1'b0;
        end else begin
          mst_d[cur] = MS_STOP;
        end
      end
      ACT_EDGE: begin
        if (e_issue) eidx_d = eidx_q + 1'b1;
        erv_d = e_issue;
        if (erv_q && e_par == cur && DomCntW'(e_dep) < dom_total_q) begin
          pend_d[e_dep] = 1'b1;
        end
      end
      default: ;
    endcase
    if (cmd_i.idx_inc) idx_d = idx_q + 1'b1;
    if (cmd_i.emit) begin
      out_valid_d          = 1'b1;
      out_d                = '0;
      out_d.status         = cmd_i.status;
      out_d.global_throttles = tsum_q;
      out_d.domains_in_use = dom_total_q;
      out_d.edges_in_use   = edge_total_q;
      out_d.last           = cmd_i.last;
      if (cmd_i.has) begin
        out_d.result_domain    = cur;
        out_d.module_state     = mst_q[cur];
        out_d.alive            = alive_q[cur];
        out_d.pending          = pend_q[cur];
        out_d.restart_total    = rcnt_q[cur];
        out_d.domain_throttles = tcnt_q[cur];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= 64'd1000;
      idx_q        <= '0;
      dom_total_q  <= '0;
      edge_total_q <= '0;
      eidx_q       <= '0;
      erv_q        <= 1'b0;
      hk_q         <= '0;
      hv_q         <= 1'b0;
      minv_q       <= 1'b0;
      tsum_q       <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NumDomains; i++) begin
        alive_q[i] <= 1'b0;
        pend_q[i]  <= 1'b0;
        mst_q[i]   <= MS_RUN;
        rcnt_q[i]  <= '0;
        tcnt_q[i]  <= '0;
        hnext_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) window_q <= cfg_wdata_i;
      idx_q        <= idx_d;
      dom_total_q  <= dom_total_d;
      edge_total_q <= edge_total_d;
      eidx_q       <= eidx_d;
      erv_q        <= erv_d;
      hk_q         <= hk_d;
      hv_q         <= hv_d;
      minv_q       <= minv_d;
      tsum_q       <= tsum_d;
      out_valid_q  <= out_valid_d;
      alive_q      <= alive_d;
      pend_q       <= pend_d;
      mst_q        <= mst_d;
      rcnt_q       <= rcnt_d;
      tcnt_q       <= tcnt_d;
      hnext_q      <= hnext_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    min_q  <= min_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_dom_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dom_total_q <= DomCntW'(NumDomains))
    else $error("domain count out of range");
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= EdgeCntW'(MaxEdges))
    else $error("edge count out of range");
  a_throttle_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == ACT_THROTTLE) |=> tsum_q == $past(tsum_q) + 64'd1)
    else $error("throttle sum not advanced");
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

endmodule

[hw/rtl/fault_domain_restart_supervisor.sv]
// fault_domain_restart_supervisor: top level, joins controller and datapath
// depends on fdrs_pkg, fdrs_ctrl, fdrs_dp (and fdrs_ram through fdrs_dp)
`timescale 1ns / 1ps
// usage:
//   in_* carries one command per transfer (register, add dependency, mark
//   pending, restart, tick, query); out_* returns result transfers, the
//   final one of each command flagged by last. cfg_we_i writes the throttle
//   window; the user must write it only while the block is idle (not checked).
//   one command at a time: in_ready_o is high only between commands, and a
//   new command may be taken while the final result still sits in the
//   output register.
//   a direct restart that succeeds then scans the edge ram one entry a
//   cycle to mark the dependents of the domain pending. a tick scans the
//   domains in order and, for each pending domain, reads its history ram
//   and compares the oldest stamp with the window when its history is
//   full, then throttles the domain or restarts it as above.
//   when the receiver stalls, the sequence waits before each result until
//   the output register frees up; nothing is dropped.
//   reset clears all domains, edges and counters and sets the window to
//   1000; no clearing pass is needed.
module fault_domain_restart_supervisor import fdrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  fdrs_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fdrs_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  fdrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fdrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sim/fault_domain_restart_supervisor_test.sv]
// fault_domain_restart_supervisor_test: self-checking bench for the restart supervisor
// depends on fdrs_pkg and fault_domain_restart_supervisor; directed table, then random traffic
`timescale 1ns / 1ps
module fault_domain_restart_supervisor_test;
  import fdrs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  fdrs_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  fdrs_out_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;

  fault_domain_restart_supervisor DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // supervisor model state
  logic [63:0] window_m;
  logic [4:0]  dom_cnt_m;
  logic [6:0]  edge_cnt_m;
  logic [63:0] thr_sum_m;
  logic        alive_m [NumDomains];
  logic        pend_m [NumDomains];
  logic [1:0]  mstate_m [NumDomains];
  logic [31:0] restarts_m [NumDomains];
  logic [31:0] thr_cnt_m [NumDomains];
  logic [63:0] stamps_m [NumDomains][HistDepth];
  logic [1:0]  hnext_m [NumDomains];
  logic [7:0]  eparent_m [MaxEdges];
  logic [7:0]  edep_m [MaxEdges];

  fdrs_out_t expected_q[$];
  int  errors = 0;
  int  send_idle = 0, recv_idle = 0;
  int  quiet = 0;

  function automatic fdrs_out_t result_of(bit has, int d, status_e st);
    fdrs_out_t r;
    r = '0;
    r.status = st;
    if (has) begin
      r.result_domain = d[3:0];
      r.module_state = mstate_m[d];
      r.alive = alive_m[d];
      r.pending = pend_m[d];
      r.restart_total = restarts_m[d];
      r.domain_throttles = thr_cnt_m[d];
    end
    r.global_throttles = thr_sum_m;
    r.domains_in_use = dom_cnt_m;
    r.edges_in_use = edge_cnt_m;
    return r;
  endfunction

  function automatic status_e run_restart(int d, fdrs_in_t c);
    alive_m[d] = 1'b0;
    if (!c.teardown_ok_mask[d]) begin
      mstate_m[d] = MS_STOP;
      return ST_TD_FAIL;
    end
    if (!c.init_ok_mask[d]) begin
      mstate_m[d] = MS_STOP;
      return ST_INIT_FAIL;
    end
    pend_m[d] = 1'b0;
    alive_m[d] = 1'b1;
    mstate_m[d] = MS_RUN;
    restarts_m[d]++;
    stamps_m[d][hnext_m[d]] = c.cur_time;
    hnext_m[d]++;
    for (int i = 0; i < edge_cnt_m; i++)
      if (eparent_m[i] == d && edep_m[i] < dom_cnt_m) pend_m[edep_m[i]] = 1'b1;
    return ST_OK;
  endfunction

  function automatic bit restarting_too_fast(int d, logic [63:0] now);
    logic [63:0] oldest;
    if (restarts_m[d] < HistDepth) return 0;
    oldest = stamps_m[d][0];
    for (int i = 1; i < HistDepth; i++)
      if (stamps_m[d][i] < oldest) oldest = stamps_m[d][i];
    return (now - oldest) < window_m;
  endfunction

  task automatic predict_command(fdrs_in_t c);
    fdrs_out_t rs[$];
    int id;
    int dp;
    bit found;
    status_e st;
    id = c.domain_id;
    dp = c.dependent_id;
    found = id < dom_cnt_m;
    case (c.opcode)
      OP_REGISTER: begin
        if (dom_cnt_m >= NumDomains) rs.push_back(result_of(0, 0, ST_REFUSED));
        else begin
          restarts_m[dom_cnt_m] = '0;
          alive_m[dom_cnt_m] = 1'b1;
          pend_m[dom_cnt_m] = 1'b0;
          mstate_m[dom_cnt_m] = MS_RUN;
          dom_cnt_m++;
          rs.push_back(result_of(1, dom_cnt_m - 1, ST_OK));
        end
      end
      OP_ADD_DEP: begin
        if (!found || dp >= dom_cnt_m) rs.push_back(result_of(found, id, ST_NOT_FOUND));
        else if (id == dp || edge_cnt_m >= MaxEdges)
          rs.push_back(result_of(1, id, ST_REFUSED));
        else begin
          eparent_m[edge_cnt_m] = id[7:0];
          edep_m[edge_cnt_m] = dp[7:0];
          edge_cnt_m++;
          rs.push_back(result_of(1, id, ST_OK));
        end
      end
      OP_MARK: begin
        if (found) pend_m[id] = 1'b1;
        rs.push_back(result_of(found, id, found ? ST_OK : ST_NOT_FOUND));
      end
      OP_RESTART: begin
        if (found) begin
          st = run_restart(id, c);
          rs.push_back(result_of(1, id, st));
        end else rs.push_back(result_of(0, 0, ST_NOT_FOUND));
      end
      OP_TICK: begin
        for (int i = 0; i < dom_cnt_m; i++) begin
          if (!pend_m[i]) continue;
          mstate_m[i] = MS_CRASH;
          if (restarting_too_fast(i, c.cur_time)) begin
            pend_m[i] = 1'b0;
            alive_m[i] = 1'b0;
            mstate_m[i] = MS_STOP;
            thr_cnt_m[i]++;
            thr_sum_m++;
            st = ST_THROTTLED;
          end else begin
            pend_m[i] = 1'b0;
            st = run_restart(i, c);
          end
          rs.push_back(result_of(1, i, st));
        end
        if (rs.size() == 0) rs.push_back(result_of(0, 0, ST_NOTHING));
      end
      OP_QUERY: rs.push_back(result_of(found, id, found ? ST_OK : ST_NOT_FOUND));
      default: rs.push_back(result_of(0, 0, ST_NOTHING));
    endcase
    rs[rs.size() - 1].last = 1'b1;
    foreach (rs[i]) expected_q.push_back(rs[i]);
  endtask

  // model reset
  initial begin
    window_m = 64'd1000;
    dom_cnt_m = '0;
    edge_cnt_m = '0;
    thr_sum_m = '0;
    for (int d = 0; d < NumDomains; d++) begin
      alive_m[d] = 0; pend_m[d] = 0; mstate_m[d] = MS_RUN;
      restarts_m[d] = '0; thr_cnt_m[d] = '0; hnext_m[d] = '0;
      for (int h = 0; h < HistDepth; h++) stamps_m[d][h] = '0;
    end
  end

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          errors++;
        end else begin
          if (out_data_o !== expected_q[0]) begin
            $display("%0t: mismatch expected %h actual %h", $time, expected_q[0], out_data_o);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 200000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_command(fdrs_in_t c);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_command(c);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_window(logic [63:0] w);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    window_m = w;
  endtask

  function automatic fdrs_in_t make_cmd(logic [2:0] op, logic [7:0] id, logic [7:0] dp,
                                        logic [63:0] now, logic [15:0] td, logic [15:0] ini);
    fdrs_in_t c;
    c.opcode = op; c.domain_id = id; c.dependent_id = dp;
    c.cur_time = now; c.teardown_ok_mask = td; c.init_ok_mask = ini;
    return c;
  endfunction

  function automatic fdrs_in_t random_cmd(logic [63:0] now);
    fdrs_in_t c;
    int r;
    r = $urandom_range(99);
    c.opcode = (r < 8) ? OP_REGISTER : (r < 22) ? OP_ADD_DEP : (r < 40) ? OP_MARK :
               (r < 58) ? OP_RESTART : (r < 85) ? OP_TICK : (r < 95) ? OP_QUERY :
               3'($urandom_range(6, 7));
    c.domain_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(17));
    c.dependent_id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(17));
    c.cur_time = ($urandom_range(15) == 0) ? {$urandom, $urandom} : now;
    c.teardown_ok_mask = ($urandom_range(3) == 0) ? 16'($urandom) : 16'hffff;
    c.init_ok_mask = ($urandom_range(3) == 0) ? 16'($urandom) : 16'hffff;
    return c;
  endfunction

  fdrs_in_t    directed_tbl[$];
  logic [63:0] clock_now;

  initial begin
    // opcode, domain, dependent, now, teardown mask, init mask
    directed_tbl = '{
      make_cmd(OP_QUERY, 8'd0, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_TICK, 8'd0, 8'd0, 64'd0, 16'hffff, 16'hffff),
      make_cmd(3'd7, 8'd0, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(3'd6, 8'hff, 8'hff, '1, '1, '1),
      make_cmd(OP_REGISTER, 8'd0, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_REGISTER, 8'd0, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_REGISTER, 8'd0, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_ADD_DEP, 8'd1, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_ADD_DEP, 8'd0, 8'd2, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_ADD_DEP, 8'd1, 8'd1, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_ADD_DEP, 8'hff, 8'd1, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_ADD_DEP, 8'd1, 8'hff, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_MARK, 8'hff, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_RESTART, 8'd1, 8'd0, 64'd5, 16'hffff, 16'hffff),
      make_cmd(OP_TICK, 8'd0, 8'd0, 64'd6, 16'hffff, 16'hffff),
      make_cmd(OP_RESTART, 8'd2, 8'd0, 64'd7, 16'h0, 16'hffff),
      make_cmd(OP_RESTART, 8'd1, 8'd0, 64'd8, 16'hffff, 16'h0),
      make_cmd(OP_RESTART, 8'd9, 8'd0, 64'd8, 16'hffff, 16'hffff),
      make_cmd(OP_RESTART, 8'd0, 8'd0, 64'd10, 16'hffff, 16'hffff),
      make_cmd(OP_RESTART, 8'd0, 8'd0, 64'd11, 16'hffff, 16'hffff),
      make_cmd(OP_RESTART, 8'd0, 8'd0, 64'd12, 16'hffff, 16'hffff),
      make_cmd(OP_MARK, 8'd0, 8'd0, 64'd0, 16'h0, 16'h0),
      make_cmd(OP_TICK, 8'd0, 8'd0, 64'd13, 16'hffff, 16'hffff),
      make_cmd(OP_QUERY, 8'd0, 8'd0, '1, '1, '1)
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 23; recv_idle = 49;
    foreach (directed_tbl[i]) begin
      // reset-time rows have results readable at a glance
      if (i < 4) begin
        fdrs_out_t want;
        want = '0;
        want.status = (directed_tbl[i].opcode == OP_QUERY) ? ST_NOT_FOUND : ST_NOTHING;
        want.last = 1'b1;
        send_command(directed_tbl[i]);
        if (expected_q[expected_q.size() - 1] !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want,
                   expected_q[expected_q.size() - 1]);
          errors++;
        end
      end else send_command(directed_tbl[i]);
    end
    write_window(64'd1);
    repeat (14) send_command(make_cmd(OP_REGISTER, 8'd0, 8'd0, 64'd0, 16'h0, 16'h0));
    // spread dependency edges over all domains with a tiny window
    for (int k = 0; k < 24; k++) begin
      logic [7:0] a, b;
      a = 8'($urandom_range(15));
      b = 8'((a + 1 + $urandom_range(14)) % 16);
      send_command(make_cmd(OP_ADD_DEP, a, b, 64'd0, 16'h0, 16'h0));
    end
    write_window('1);
    clock_now = 64'd100;
    for (int n = 0; n < 40; n++) begin
      if (n == 12) begin
        write_window(64'd40);
        send_idle = 49; recv_idle = 23;
      end
      if (n == 22) begin
        drain_results();
      end
      if (n == 28) begin
        write_window(64'd1000);
        send_idle = 0; recv_idle = 0;
      end
      clock_now += $urandom_range(20);
      send_command(random_cmd(clock_now));
    end
    drain_results();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
